>>> rtl/pbrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbrs_pkg
// Shared constants, types and helpers of the priority batch request scheduler.
// ----------------------------------------------------------------------------
package pbrs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int BATCH_LIMIT = 16;
   localparam int NUM_QUEUES  = 3;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W  = $clog2(MEM_DEPTH);
   localparam int TAKEN_W = $clog2(BATCH_LIMIT + 1);
   localparam int TOT_W   = $clog2(MEM_DEPTH + 1);

   localparam logic [1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [1:0] OP_SCAN     = 2'd1;
   localparam logic [1:0] OP_COLLECT  = 2'd2;
   localparam logic [1:0] OP_COMPLETE = 2'd3;

   localparam logic [1:0] PRIO_HIGH = 2'd0;
   localparam logic [1:0] PRIO_LOW  = 2'd2;

   localparam logic [1:0] Q_HIGH = 2'd0;
   localparam logic [1:0] Q_MID  = 2'd1;
   localparam logic [1:0] Q_LOW  = 2'd2;

   localparam logic [1:0] CSR_MAX_BATCH  = 2'd0;
   localparam logic [1:0] CSR_MAX_PEND   = 2'd1;
   localparam logic [1:0] CSR_MAX_ACTIVE = 2'd2;

   localparam logic [2:0] KIND_ACCEPTED     = 3'd0;
   localparam logic [2:0] KIND_REJECTED     = 3'd1;
   localparam logic [2:0] KIND_EXPIRED      = 3'd2;
   localparam logic [2:0] KIND_DISPATCHED   = 3'd3;
   localparam logic [2:0] KIND_BUSY         = 3'd4;
   localparam logic [2:0] KIND_EMPTY        = 3'd5;
   localparam logic [2:0] KIND_ACK          = 3'd6;
   localparam logic [2:0] KIND_NONE_EXPIRED = 3'd7;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] deadline;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } ram_wr_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      return (int'(ptr) == QUEUE_DEPTH - 1) ? '0 : PTR_W'(int'(ptr) + 1);
   endfunction

   function automatic logic [ADDR_W-1:0] ram_addr(input logic [1:0] q,
                                                  input logic [PTR_W-1:0] ptr);
      return ADDR_W'(int'(q) * QUEUE_DEPTH + int'(ptr));
   endfunction

endpackage

>>> rtl/pbrs_queue_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbrs_queue_ram
// Request store for all three queues: one write port, one registered read.
// ----------------------------------------------------------------------------
module pbrs_queue_ram (
   input  logic                     clock,
   input  pbrs_pkg::ram_wr_type     wr,
   input  logic [pbrs_pkg::ADDR_W-1:0] rd_addr,
   output pbrs_pkg::entry_type      rd_data
);
   import pbrs_pkg::*;

   entry_type mem_ff [MEM_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> rtl/priority_batch_request_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_batch_request_scheduler_unit
// Strict priority request queues with expiry scan and batch dequeue.
// ----------------------------------------------------------------------------
// enqueue, completion and busy collect: a single result.
// scan: a result per expired entry; collect: a result per popped entry,
// stopping at the batch limit or once all queues are empty.
// synchronous reset empties all queues and restores the id counter, the
// active count and the csr limits. busy drops as the last result shows,
// so the next start is taken that cycle; results cannot be stalled.
module priority_batch_request_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [1:0]  req_priority_req,
   input  logic [31:0] req_deadline,
   input  logic [31:0] req_current_time,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_request_id,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);
   import pbrs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN_RD, ST_SCAN_EV, ST_COL_RD, ST_COL_EV, ST_DONE
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   count_ff [NUM_QUEUES];
   logic [PTR_W-1:0]   head_ff  [NUM_QUEUES];
   logic [31:0]        next_id_ff;
   logic [7:0]         active_ff;
   logic [4:0]         max_batch_ff;
   logic [5:0]         max_pend_ff;
   logic [7:0]         max_active_ff;
   logic [1:0]         op_ff;
   logic [31:0]        time_ff;
   logic [1:0]         q_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   keep_ff;
   logic [TAKEN_W-1:0] taken_ff;
   logic [TAKEN_W-1:0] limit_ff;
   logic               any_ff;
   logic               pend_valid_ff;
   logic [2:0]         pend_kind_ff;
   logic [31:0]        pend_id_ff;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_kind_ff;
   logic [31:0]        rsp_id_ff;
   logic               rsp_last_ff;

   logic [1:0]         sel_in;
   logic               reject_in;
   logic [PTR_W-1:0]   tail_in;
   logic [TAKEN_W-1:0] limit_in;
   logic [TOT_W-1:0]   total_in;
   logic               expired_in;
   logic               new_valid_in;
   logic [2:0]         new_kind_in;
   logic [31:0]        new_id_in;
   logic [ADDR_W-1:0]  rd_addr_in;
   ram_wr_type         wr_in;
   entry_type          rd_data;
   int                 tail_sum;

   pbrs_queue_ram u_ram (
      .clock   (clock),
      .wr      (wr_in),
      .rd_addr (rd_addr_in),
      .rd_data (rd_data)
   );

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_request_id = rsp_id_ff;
   assign rsp_last       = rsp_last_ff;

   always_comb begin
      if (req_priority_req == PRIO_HIGH) begin
         sel_in = Q_HIGH;
      end else if (req_priority_req == PRIO_LOW) begin
         sel_in = Q_LOW;
      end else begin
         sel_in = Q_MID;
      end
      total_in  = TOT_W'(int'(count_ff[0]) + int'(count_ff[1]) + int'(count_ff[2]));
      reject_in = ((max_pend_ff != 6'd0) && (int'(total_in) >= int'(max_pend_ff))) ||
                  (int'(count_ff[sel_in]) >= QUEUE_DEPTH);
      tail_sum  = int'(head_ff[sel_in]) + int'(count_ff[sel_in]);
      if (tail_sum >= QUEUE_DEPTH) begin
         tail_sum = tail_sum - QUEUE_DEPTH;
      end
      tail_in = PTR_W'(tail_sum);
      if (max_batch_ff == 5'd0) begin
         limit_in = TAKEN_W'(1);
      end else if (int'(max_batch_ff) > BATCH_LIMIT) begin
         limit_in = TAKEN_W'(BATCH_LIMIT);
      end else begin
         limit_in = TAKEN_W'(max_batch_ff);
      end

      // the one deadline comparator, shared by scan and collect
      expired_in = (rd_data.deadline != 32'd0) && (rd_data.deadline < time_ff);

      new_valid_in = 1'b0;
      new_kind_in  = KIND_EXPIRED;
      new_id_in    = rd_data.id;
      wr_in.en     = 1'b0;
      wr_in.addr   = ram_addr(q_ff, wr_ptr_ff);
      wr_in.data   = rd_data;
      rd_addr_in   = ram_addr(q_ff, rd_ptr_ff);
      case (state_ff)
         ST_IDLE: begin
            wr_in.addr      = ram_addr(sel_in, tail_in);
            wr_in.data.id   = next_id_ff;
            wr_in.data.deadline = req_deadline;
            wr_in.en        = start && (req_operation == OP_ENQUEUE) && !reject_in;
         end
         ST_SCAN_EV: begin
            new_valid_in = expired_in;
            wr_in.en     = !expired_in;
         end
         ST_COL_RD: begin
            rd_addr_in = ram_addr(q_ff, head_ff[q_ff]);
         end
         ST_COL_EV: begin
            new_valid_in = 1'b1;
            new_kind_in  = expired_in ? KIND_EXPIRED : KIND_DISPATCHED;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         for (int k = 0; k < NUM_QUEUES; k++) begin
            count_ff[k] <= '0;
            head_ff[k]  <= '0;
         end
         next_id_ff    <= 32'd1;
         active_ff     <= 8'd0;
         max_batch_ff  <= 5'd8;
         max_pend_ff   <= 6'd0;
         max_active_ff <= 8'd2;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= (new_valid_in && pend_valid_ff) || (state_ff == ST_DONE);
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAX_BATCH:  max_batch_ff  <= csr_write_data[4:0];
               CSR_MAX_PEND:   max_pend_ff   <= csr_write_data[5:0];
               CSR_MAX_ACTIVE: max_active_ff <= (csr_write_data == 8'd0) ? 8'd1
                                                                         : csr_write_data;
               default: begin
               end
            endcase
         end
         // one result held back so the final beat can carry last
         if (new_valid_in) begin
            if (pend_valid_ff) begin
               rsp_kind_ff  <= pend_kind_ff;
               rsp_id_ff    <= pend_id_ff;
               rsp_last_ff  <= 1'b0;
            end
            pend_valid_ff <= 1'b1;
            pend_kind_ff  <= new_kind_in;
            pend_id_ff    <= new_id_in;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff    <= req_operation;
                  time_ff  <= req_current_time;
                  q_ff     <= Q_HIGH;
                  taken_ff <= '0;
                  limit_ff <= limit_in;
                  any_ff   <= 1'b0;
                  case (req_operation)
                     OP_ENQUEUE: begin
                        pend_valid_ff <= 1'b1;
                        if (reject_in) begin
                           pend_kind_ff <= KIND_REJECTED;
                           pend_id_ff   <= 32'd0;
                        end else begin
                           pend_kind_ff     <= KIND_ACCEPTED;
                           pend_id_ff       <= next_id_ff;
                           next_id_ff       <= next_id_ff + 32'd1;
                           count_ff[sel_in] <= count_ff[sel_in] + CNT_W'(1);
                        end
                        state_ff <= ST_DONE;
                     end
                     OP_SCAN: begin
                        rd_ptr_ff <= head_ff[0];
                        wr_ptr_ff <= head_ff[0];
                        idx_ff    <= '0;
                        keep_ff   <= '0;
                        state_ff  <= ST_SCAN_RD;
                     end
                     OP_COLLECT: begin
                        if (active_ff >= max_active_ff) begin
                           pend_valid_ff <= 1'b1;
                           pend_kind_ff  <= KIND_BUSY;
                           pend_id_ff    <= 32'd0;
                           state_ff      <= ST_DONE;
                        end else begin
                           state_ff <= ST_COL_RD;
                        end
                     end
                     default: begin
                        if (active_ff != 8'd0) begin
                           active_ff <= active_ff - 8'd1;
                        end
                        pend_valid_ff <= 1'b1;
                        pend_kind_ff  <= KIND_ACK;
                        pend_id_ff    <= 32'd0;
                        state_ff      <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_SCAN_RD: begin
               if (idx_ff == count_ff[q_ff]) begin
                  count_ff[q_ff] <= keep_ff;
                  if (q_ff == Q_LOW) begin
                     state_ff <= ST_DONE;
                  end else begin
                     q_ff      <= q_ff + 2'd1;
                     rd_ptr_ff <= head_ff[q_ff + 2'd1];
                     wr_ptr_ff <= head_ff[q_ff + 2'd1];
                     idx_ff    <= '0;
                     keep_ff   <= '0;
                  end
               end else begin
                  state_ff <= ST_SCAN_EV;
               end
            end
            ST_SCAN_EV: begin
               // survivors slide toward the head in order
               if (!expired_in) begin
                  wr_ptr_ff <= ptr_inc(wr_ptr_ff);
                  keep_ff   <= keep_ff + CNT_W'(1);
               end
               rd_ptr_ff <= ptr_inc(rd_ptr_ff);
               idx_ff    <= idx_ff + CNT_W'(1);
               state_ff  <= ST_SCAN_RD;
            end
            ST_COL_RD: begin
               if (taken_ff == limit_ff) begin
                  state_ff <= ST_DONE;
               end else if (count_ff[q_ff] == '0) begin
                  if (q_ff == Q_LOW) begin
                     state_ff <= ST_DONE;
                  end else begin
                     q_ff <= q_ff + 2'd1;
                  end
               end else begin
                  state_ff <= ST_COL_EV;
               end
            end
            ST_COL_EV: begin
               head_ff[q_ff]  <= ptr_inc(head_ff[q_ff]);
               count_ff[q_ff] <= count_ff[q_ff] - CNT_W'(1);
               taken_ff       <= taken_ff + TAKEN_W'(1);
               if (!expired_in) begin
                  any_ff <= 1'b1;
               end
               state_ff <= ST_COL_RD;
            end
            ST_DONE: begin
               rsp_last_ff   <= 1'b1;
               pend_valid_ff <= 1'b0;
               if (pend_valid_ff) begin
                  rsp_kind_ff <= pend_kind_ff;
                  rsp_id_ff   <= pend_id_ff;
               end else begin
                  rsp_kind_ff <= (op_ff == OP_SCAN) ? KIND_NONE_EXPIRED : KIND_EMPTY;
                  rsp_id_ff   <= 32'd0;
               end
               if ((op_ff == OP_COLLECT) && any_ff && (active_ff != 8'hFF)) begin
                  active_ff <= active_ff + 8'd1;
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/pbrs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbrs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pbrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [2:0]  rsp_kind,
   input logic        rsp_last
);
   import pbrs_pkg::*;

   // a new command never ends in the cycle after its start
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted command did not raise busy");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid) else $error("beat right after last beat");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy) else $error("non-final beat while idle");

   a_single_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_BUSY || rsp_kind == KIND_EMPTY ||
                    rsp_kind == KIND_ACK || rsp_kind == KIND_NONE_EXPIRED ||
                    rsp_kind == KIND_ACCEPTED || rsp_kind == KIND_REJECTED)
      |-> rsp_last) else $error("single-beat kind without last");

endmodule

bind priority_batch_request_scheduler_unit pbrs_checker u_pbrs_checker (.*);
